// File: src/mlr_pkg.sv
package mlr_pkg;

  localparam int COORD_BITS    = 12;
  localparam int DEPTH_BITS    = 16;
  localparam int CFG_BITS      = 11;
  localparam int APB_DATA_BITS = 32;
  localparam int APB_ADDR_BITS = 3;

  // mirrored coordinates need one more bit than the screen coordinates
  localparam int POS_BITS  = COORD_BITS + 1;
  localparam int LEN_BITS  = COORD_BITS;
  localparam int DEC_BITS  = COORD_BITS + 3;
  localparam int PROD_BITS = LEN_BITS + DEPTH_BITS;
  localparam int CNT_BITS  = $clog2(DEPTH_BITS);
  localparam int WIN_BITS  = (COORD_BITS + 2 > CFG_BITS + 1) ? COORD_BITS + 2 : CFG_BITS + 1;

  localparam logic [CFG_BITS-1:0] HALF_WIDTH_RST  = CFG_BITS'(300);
  localparam logic [CFG_BITS-1:0] HALF_HEIGHT_RST = CFG_BITS'(240);
  localparam logic [CNT_BITS-1:0] DIV_LAST_CNT    = CNT_BITS'(DEPTH_BITS - 1);

  typedef enum logic {
    REG_HALF_WIDTH  = 1'b0,
    REG_HALF_HEIGHT = 1'b1
  } reg_idx_e;

  typedef enum logic {
    OP_START = 1'b0,
    OP_STEP  = 1'b1
  } op_e;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_MUL  = 4'b0010,
    S_DIV  = 4'b0100,
    S_OUT  = 4'b1000
  } state_e;

  typedef struct packed {
    logic                         op;
    logic signed [COORD_BITS-1:0] x_start;
    logic signed [COORD_BITS-1:0] y_start;
    logic signed [DEPTH_BITS-1:0] z_start;
    logic signed [COORD_BITS-1:0] x_end;
    logic signed [COORD_BITS-1:0] y_end;
    logic signed [DEPTH_BITS-1:0] z_end;
  } line_in_t;

  typedef struct packed {
    logic                         pixel_valid;
    logic signed [COORD_BITS-1:0] pix_x;
    logic signed [COORD_BITS-1:0] pix_y;
    logic signed [DEPTH_BITS-1:0] pix_z;
    logic                         in_window;
    logic                         last_pixel;
  } pixel_out_t;

endpackage

// File: src/midpoint_line_rasterizer.sv
// Midpoint line rasterizer, all eight octants, with linear depth.
// Input channel (in_valid_i/in_ready_o/in_data_i): a start transfer (op 0) sets up a
// line from its two endpoints and yields the first pixel; each step transfer (op 1)
// yields the next pixel. Every input transfer gives exactly one output transfer
// (out_valid_o/out_ready_i/out_data_o); a step with no line running gives pixel_valid 0.
// Sequence: a line pixel goes through the multiply state, the depth divider and the
// output state; the divider produces one quotient bit per cycle. A zero-length line
// skips the divider, and a step with no line running goes straight to the output state.
// The block handles one item at a time; in_ready_o is high only while the sequencer idles.
// A finished pixel sits in the output register, so a new item is taken while the
// receiver stalls; that item then waits at its end until the output register frees up.
// Window half sizes are written over the APB port (half_width at 0x0, half_height at 0x4);
// the user must change them only while the block is idle, which the block does not enforce.
// Reset clears the sequencer, the output valid flag and the running line, and loads the
// half sizes with 300 and 240.
module midpoint_line_rasterizer
  import mlr_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,

  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  line_in_t                 in_data_i,

  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output pixel_out_t               out_data_o,

  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [APB_ADDR_BITS-1:0] paddr,
  input  logic [APB_DATA_BITS-1:0] pwdata,
  output logic [APB_DATA_BITS-1:0] prdata,
  output logic                     pready
);

  // configuration
  logic [CFG_BITS-1:0] half_width_q, half_height_q;
  logic                cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_width_q  <= HALF_WIDTH_RST;
      half_height_q <= HALF_HEIGHT_RST;
    end else if (cfg_wr) begin
      unique case (reg_idx_e'(paddr[2]))
        REG_HALF_WIDTH:  half_width_q  <= pwdata[CFG_BITS-1:0];
        REG_HALF_HEIGHT: half_height_q <= pwdata[CFG_BITS-1:0];
        default:         half_width_q  <= half_width_q;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx_e'(paddr[2]))
      REG_HALF_WIDTH:  prdata = APB_DATA_BITS'(half_width_q);
      REG_HALF_HEIGHT: prdata = APB_DATA_BITS'(half_height_q);
      default:         prdata = '0;
    endcase
  end

  // line state
  state_e                      state_q, state_d;
  logic                        line_active_q, line_active_d;
  logic                        swap_q, swap_d, negx_q, negx_d, negy_q, negy_d;
  logic signed [POS_BITS-1:0]  major_pos_q, major_pos_d, minor_pos_q, minor_pos_d;
  logic signed [POS_BITS-1:0]  major_start_q, major_start_d, major_end_q, major_end_d;
  logic signed [DEC_BITS-1:0]  dec_q, dec_d, inc_e_q, inc_e_d, inc_ne_q, inc_ne_d;
  logic signed [DEPTH_BITS-1:0] zs_q, zs_d, ze_q, ze_d;
  logic                        last_q, last_d, emit_q, emit_d;

  // divider
  logic [CNT_BITS-1:0]   cnt_q, cnt_d;
  logic [LEN_BITS-1:0]   rem_q, rem_d;
  logic [DEPTH_BITS-1:0] quo_q, quo_d;
  logic                  neg_q, neg_d;

  // output register
  logic       out_valid_q, out_valid_d;
  pixel_out_t out_q, out_d;

  logic in_xfer;

  assign in_ready_o  = (state_q == S_IDLE);
  assign in_xfer     = in_valid_i & in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // setup of a new line
  logic signed [POS_BITS-1:0] x0, y0, x1, y1, dx, dy, adx_w, ady_w;
  logic signed [POS_BITS-1:0] sx0, sx1, sy0, sy1;
  logic [LEN_BITS-1:0]        adx, ady, dmaj, dmin;
  logic signed [DEC_BITS-1:0] dmin_x2, dmaj_x1, dmaj_x2;
  logic                       nx, ny, sw;

  always_comb begin
    x0 = POS_BITS'(in_data_i.x_start);
    y0 = POS_BITS'(in_data_i.y_start);
    x1 = POS_BITS'(in_data_i.x_end);
    y1 = POS_BITS'(in_data_i.y_end);
    dx = x1 - x0;
    dy = y1 - y0;
    nx = (x1 < x0);
    ny = (y1 < y0);
    adx_w = nx ? -dx : dx;
    ady_w = ny ? -dy : dy;
    adx = adx_w[LEN_BITS-1:0];
    ady = ady_w[LEN_BITS-1:0];
    sx0 = nx ? -x0 : x0;
    sx1 = nx ? -x1 : x1;
    sy0 = ny ? -y0 : y0;
    sy1 = ny ? -y1 : y1;
    sw = (ady > adx);
    dmaj = sw ? ady : adx;
    dmin = sw ? adx : ady;
    dmin_x2 = DEC_BITS'({dmin, 1'b0});
    dmaj_x1 = DEC_BITS'(dmaj);
    dmaj_x2 = DEC_BITS'({dmaj, 1'b0});
  end

  // depth product and divider step
  logic [LEN_BITS-1:0]          len, off;
  logic signed [POS_BITS-1:0]   len_w, off_w;
  logic signed [DEPTH_BITS:0]   dz, dz_abs;
  logic [DEPTH_BITS-1:0]        dz_mag;
  logic [PROD_BITS-1:0]         prod;
  logic [LEN_BITS:0]            trial, trial_sub;
  logic                         trial_ge;

  always_comb begin
    len_w     = major_end_q - major_start_q;
    off_w     = major_pos_q - major_start_q;
    len       = len_w[LEN_BITS-1:0];
    off       = off_w[LEN_BITS-1:0];
    dz        = (DEPTH_BITS+1)'(ze_q) - (DEPTH_BITS+1)'(zs_q);
    dz_abs    = dz[DEPTH_BITS] ? -dz : dz;
    dz_mag    = dz_abs[DEPTH_BITS-1:0];
    prod      = PROD_BITS'(off) * PROD_BITS'(dz_mag);
    trial     = {rem_q, quo_q[DEPTH_BITS-1]};
    trial_ge  = (trial >= {1'b0, len});
    trial_sub = trial - {1'b0, len};
  end

  // pixel in screen coordinates
  logic signed [POS_BITS-1:0]   pa, pb;
  logic signed [WIN_BITS-1:0]   px, py, hw, hh;
  logic signed [DEPTH_BITS:0]   q_s, z_sum;
  logic                         inw, out_free;

  always_comb begin
    pa    = swap_q ? minor_pos_q : major_pos_q;
    pb    = swap_q ? major_pos_q : minor_pos_q;
    px    = negx_q ? -WIN_BITS'(pa) : WIN_BITS'(pa);
    py    = negy_q ? -WIN_BITS'(pb) : WIN_BITS'(pb);
    hw    = $signed(WIN_BITS'(half_width_q));
    hh    = $signed(WIN_BITS'(half_height_q));
    inw   = (px >= -hw) && (px < hw) && (py >= -hh) && (py < hh);
    q_s   = neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});
    z_sum = (DEPTH_BITS+1)'(zs_q) + q_s;
    out_free = ~out_valid_q | out_ready_i;
  end

  // sequencer
  always_comb begin
    state_d       = state_q;
    line_active_d = line_active_q;
    swap_d        = swap_q;
    negx_d        = negx_q;
    negy_d        = negy_q;
    major_pos_d   = major_pos_q;
    minor_pos_d   = minor_pos_q;
    major_start_d = major_start_q;
    major_end_d   = major_end_q;
    dec_d         = dec_q;
    inc_e_d       = inc_e_q;
    inc_ne_d      = inc_ne_q;
    zs_d          = zs_q;
    ze_d          = ze_q;
    last_d        = last_q;
    emit_d        = emit_q;
    cnt_d         = cnt_q;
    rem_d         = rem_q;
    quo_d         = quo_q;
    neg_d         = neg_q;
    out_valid_d   = out_valid_q & ~out_ready_i;
    out_d         = out_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          if (in_data_i.op == OP_START) begin
            swap_d        = sw;
            negx_d        = nx;
            negy_d        = ny;
            major_start_d = sw ? sy0 : sx0;
            major_end_d   = sw ? sy1 : sx1;
            major_pos_d   = sw ? sy0 : sx0;
            minor_pos_d   = sw ? sx0 : sy0;
            dec_d         = dmin_x2 - dmaj_x1;
            inc_e_d       = dmin_x2;
            inc_ne_d      = dmin_x2 - dmaj_x2;
            zs_d          = in_data_i.z_start;
            ze_d          = in_data_i.z_end;
            last_d        = (dmaj == '0);
            line_active_d = (dmaj != '0);
            emit_d        = 1'b1;
            state_d       = S_MUL;
          end else if (line_active_q) begin
            if (dec_q <= 0) begin
              dec_d = dec_q + inc_e_q;
            end else begin
              dec_d       = dec_q + inc_ne_q;
              minor_pos_d = minor_pos_q + POS_BITS'(1);
            end
            major_pos_d   = major_pos_q + POS_BITS'(1);
            last_d        = (major_pos_d >= major_end_q);
            line_active_d = ~last_d;
            emit_d        = 1'b1;
            state_d       = S_MUL;
          end else begin
            emit_d  = 1'b0;
            state_d = S_OUT;
          end
        end
      end
      S_MUL: begin
        rem_d = prod[PROD_BITS-1:DEPTH_BITS];
        quo_d = prod[DEPTH_BITS-1:0];
        neg_d = dz[DEPTH_BITS];
        cnt_d = DIV_LAST_CNT;
        if (len == '0) begin
          quo_d   = '0;
          state_d = S_OUT;
        end else begin
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        rem_d = trial_ge ? trial_sub[LEN_BITS-1:0] : trial[LEN_BITS-1:0];
        quo_d = {quo_q[DEPTH_BITS-2:0], trial_ge};
        cnt_d = cnt_q - CNT_BITS'(1);
        if (cnt_q == '0) begin
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          if (emit_q) begin
            out_d.pixel_valid = 1'b1;
            out_d.pix_x       = px[COORD_BITS-1:0];
            out_d.pix_y       = py[COORD_BITS-1:0];
            out_d.pix_z       = z_sum[DEPTH_BITS-1:0];
            out_d.in_window   = inw;
            out_d.last_pixel  = last_q;
          end else begin
            out_d = '0;
          end
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      line_active_q <= 1'b0;
      out_valid_q   <= 1'b0;
      cnt_q         <= '0;
    end else begin
      state_q       <= state_d;
      line_active_q <= line_active_d;
      out_valid_q   <= out_valid_d;
      cnt_q         <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    swap_q        <= swap_d;
    negx_q        <= negx_d;
    negy_q        <= negy_d;
    major_pos_q   <= major_pos_d;
    minor_pos_q   <= minor_pos_d;
    major_start_q <= major_start_d;
    major_end_q   <= major_end_d;
    dec_q         <= dec_d;
    inc_e_q       <= inc_e_d;
    inc_ne_q      <= inc_ne_d;
    zs_q          <= zs_d;
    ze_q          <= ze_d;
    last_q        <= last_d;
    emit_q        <= emit_d;
    rem_q         <= rem_d;
    quo_q         <= quo_d;
    neg_q         <= neg_d;
    out_q         <= out_d;
  end

  // divider remainder stays below the line length
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DIV |-> rem_q < len)
    else $error("divider remainder out of range");

  // a running line has not yet reached its end
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    line_active_q |-> major_pos_q < major_end_q)
    else $error("active line past its end");

  // the last pixel closes the line
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OUT && emit_q && last_q) |-> !line_active_q)
    else $error("line still active on last pixel");

  // a step without a line goes straight to the output
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && in_data_i.op == OP_STEP && !line_active_q) |=> state_q == S_OUT)
    else $error("idle step did not bypass the divider");

endmodule

// File: verif/midpoint_line_rasterizer_tb.sv
`timescale 1ns / 1ps

module midpoint_line_rasterizer_tb;
  import mlr_pkg::*;

  localparam int CYCLE_LIMIT = 600000;

  logic                     clk_i = 1'b0;
  logic                     rst_ni;
  logic                     in_valid_i;
  logic                     in_ready_o;
  line_in_t                 in_data_i;
  logic                     out_valid_o;
  logic                     out_ready_i = 1'b0;
  pixel_out_t               out_data_o;
  logic                     psel;
  logic                     penable;
  logic                     pwrite;
  logic [APB_ADDR_BITS-1:0] paddr;
  logic [APB_DATA_BITS-1:0] pwdata;
  logic [APB_DATA_BITS-1:0] prdata;
  logic                     pready;

  midpoint_line_rasterizer dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // predicted line walker state
  bit run_on, run_swap, run_negx, run_negy;
  int run_major, run_minor, run_major_first, run_major_last;
  int run_err, run_err_east, run_err_diag;
  int run_z_first, run_z_last;
  int win_half_w = 300;
  int win_half_h = 240;

  pixel_out_t pending_pixels[$];
  int mismatches = 0;
  int items_sent = 0;
  int tx_burst = 0;
  int cycles = 0;

  function automatic pixel_out_t place_pixel(bit last);
    pixel_out_t px;
    int a, b, x, y, len;
    longint z;
    a = run_swap ? run_minor : run_major;
    b = run_swap ? run_major : run_minor;
    x = run_negx ? -a : a;
    y = run_negy ? -b : b;
    len = run_major_last - run_major_first;
    z = run_z_first;
    if (len > 0) begin
      z = run_z_first + longint'(run_major - run_major_first) *
          longint'(run_z_last - run_z_first) / longint'(len);
    end
    px.pixel_valid = 1'b1;
    px.pix_x = x[COORD_BITS-1:0];
    px.pix_y = y[COORD_BITS-1:0];
    px.pix_z = z[DEPTH_BITS-1:0];
    px.in_window = (x >= -win_half_w) && (x < win_half_w) &&
                   (y >= -win_half_h) && (y < win_half_h);
    px.last_pixel = last;
    return px;
  endfunction

  function automatic pixel_out_t next_pixel(line_in_t item);
    pixel_out_t px;
    int x0, y0, x1, y1, adx, ady, sx0, sx1, sy0, sy1, dmaj, dmin;
    bit last;
    px = '0;
    if (item.op == OP_START) begin
      x0 = $signed(item.x_start);
      y0 = $signed(item.y_start);
      x1 = $signed(item.x_end);
      y1 = $signed(item.y_end);
      run_negx = x1 < x0;
      run_negy = y1 < y0;
      adx = run_negx ? x0 - x1 : x1 - x0;
      ady = run_negy ? y0 - y1 : y1 - y0;
      sx0 = run_negx ? -x0 : x0;
      sx1 = run_negx ? -x1 : x1;
      sy0 = run_negy ? -y0 : y0;
      sy1 = run_negy ? -y1 : y1;
      run_swap = ady > adx;
      if (!run_swap) begin
        run_major_first = sx0;
        run_major_last = sx1;
        run_minor = sy0;
        dmaj = adx;
        dmin = ady;
      end else begin
        run_major_first = sy0;
        run_major_last = sy1;
        run_minor = sx0;
        dmaj = ady;
        dmin = adx;
      end
      run_major = run_major_first;
      run_err = 2 * dmin - dmaj;
      run_err_east = 2 * dmin;
      run_err_diag = 2 * (dmin - dmaj);
      run_z_first = $signed(item.z_start);
      run_z_last = $signed(item.z_end);
      last = run_major >= run_major_last;
      run_on = !last;
      return place_pixel(last);
    end
    if (!run_on) return px;
    if (run_err <= 0) begin
      run_err += run_err_east;
    end else begin
      run_minor += 1;
      run_err += run_err_diag;
    end
    run_major += 1;
    last = run_major >= run_major_last;
    if (last) run_on = 1'b0;
    return place_pixel(last);
  endfunction

  task automatic report_mismatch(string what, logic signed [31:0] want,
                                 logic signed [31:0] got);
    $display("mismatch %s: expected %0d, got %0d", what, want, got);
    mismatches++;
  endtask

  always @(posedge clk_i) begin : check_pixels
    pixel_out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_pixels.size() == 0) begin
        report_mismatch("pixel with nothing pending", 0, 1);
      end else begin
        want = pending_pixels.pop_front();
        if (out_data_o.pixel_valid !== want.pixel_valid)
          report_mismatch("pixel_valid", want.pixel_valid, out_data_o.pixel_valid);
        if (out_data_o.pix_x !== want.pix_x)
          report_mismatch("pix_x", want.pix_x, out_data_o.pix_x);
        if (out_data_o.pix_y !== want.pix_y)
          report_mismatch("pix_y", want.pix_y, out_data_o.pix_y);
        if (out_data_o.pix_z !== want.pix_z)
          report_mismatch("pix_z", want.pix_z, out_data_o.pix_z);
        if (out_data_o.in_window !== want.in_window)
          report_mismatch("in_window", want.in_window, out_data_o.in_window);
        if (out_data_o.last_pixel !== want.last_pixel)
          report_mismatch("last_pixel", want.last_pixel, out_data_o.last_pixel);
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // receiver: always ready, coin flips, or long stalls, switching now and then
  int rx_mode = 0;
  int rx_span = 0;
  int rx_hold = 0;

  always @(negedge clk_i) begin
    if (rx_span == 0) begin
      rx_mode = $urandom_range(0, 2);
      rx_span = $urandom_range(50, 400);
    end else begin
      rx_span--;
    end
    case (rx_mode)
      0: begin
        out_ready_i <= 1'b1;
      end
      1: begin
        out_ready_i <= ($urandom_range(0, 1) == 1);
      end
      default: begin
        if (rx_hold != 0) begin
          rx_hold--;
          out_ready_i <= 1'b0;
        end else begin
          out_ready_i <= 1'b1;
          rx_hold = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 40) : 0;
        end
      end
    endcase
  end

  task automatic send_item(line_in_t item);
    int gap;
    if (tx_burst == 0) begin
      tx_burst = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
      repeat (gap) @(negedge clk_i);
    end
    tx_burst--;
    @(negedge clk_i);
    in_data_i <= item;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    pending_pixels.push_back(next_pixel(item));
    items_sent++;
    @(negedge clk_i);
    in_valid_i <= 1'b0;
  endtask

  task automatic write_half(reg_idx_e idx, logic [APB_DATA_BITS-1:0] value);
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= APB_ADDR_BITS'(4 * int'(idx));
    pwdata <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == REG_HALF_WIDTH) win_half_w = int'(value[CFG_BITS-1:0]);
    else win_half_h = int'(value[CFG_BITS-1:0]);
  endtask

  task automatic settle_block();
    while (pending_pixels.size() != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
  endtask

  function automatic int clamp_coord(int v);
    if (v < -2048) return -2048;
    if (v > 2047) return 2047;
    return v;
  endfunction

  function automatic int rand_depth();
    case ($urandom_range(0, 5))
      0: return -32768;
      1: return 32767;
      default: return int'($urandom_range(0, 65535)) - 32768;
    endcase
  endfunction

  function automatic int pick_coord(int half);
    case ($urandom_range(0, 3))
      0: return int'($urandom_range(0, 4095)) - 2048;
      1: return int'($urandom_range(0, 24)) - 12;
      2: return clamp_coord(half + int'($urandom_range(0, 8)) - 4);
      default: return clamp_coord(-half + int'($urandom_range(0, 8)) - 4);
    endcase
  endfunction

  function automatic line_in_t make_line(int x0, int y0, int z0, int x1, int y1, int z1);
    line_in_t item;
    item.op = OP_START;
    item.x_start = x0[COORD_BITS-1:0];
    item.y_start = y0[COORD_BITS-1:0];
    item.z_start = z0[DEPTH_BITS-1:0];
    item.x_end = x1[COORD_BITS-1:0];
    item.y_end = y1[COORD_BITS-1:0];
    item.z_end = z1[DEPTH_BITS-1:0];
    return item;
  endfunction

  function automatic line_in_t noise_item();
    logic [95:0] raw;
    raw = {$urandom(), $urandom(), $urandom()};
    return line_in_t'(raw[$bits(line_in_t)-1:0]);
  endfunction

  function automatic line_in_t make_step();
    line_in_t item;
    item = noise_item();
    item.op = OP_STEP;
    return item;
  endfunction

  task automatic send_short_line();
    int x0, y0, x1, y1, span, len, adx, ady, steps;
    x0 = pick_coord(win_half_w);
    y0 = pick_coord(win_half_h);
    span = ($urandom_range(0, 2) == 0) ? 2 : 20;
    x1 = clamp_coord(x0 + int'($urandom_range(0, 2 * span)) - span);
    y1 = clamp_coord(y0 + int'($urandom_range(0, 2 * span)) - span);
    adx = (x1 > x0) ? x1 - x0 : x0 - x1;
    ady = (y1 > y0) ? y1 - y0 : y0 - y1;
    len = (adx > ady) ? adx : ady;
    if ($urandom_range(0, 9) == 0) steps = $urandom_range(0, len);
    else steps = len + (($urandom_range(0, 4) == 0) ? 1 : 0);
    send_item(make_line(x0, y0, rand_depth(), x1, y1, rand_depth()));
    repeat (steps) send_item(make_step());
  endtask

  task automatic send_long_line();
    int x0, y0, x1, y1;
    x0 = int'($urandom_range(0, 4095)) - 2048;
    y0 = int'($urandom_range(0, 4095)) - 2048;
    x1 = int'($urandom_range(0, 4095)) - 2048;
    y1 = int'($urandom_range(0, 4095)) - 2048;
    send_item(make_line(x0, y0, rand_depth(), x1, y1, rand_depth()));
    repeat ($urandom_range(0, 6)) send_item(make_step());
  endtask

  task automatic run_traffic(int count);
    int first;
    int kind;
    first = items_sent;
    while (items_sent - first < count) begin
      kind = $urandom_range(0, 99);
      if (kind < 72) send_short_line();
      else if (kind < 87) send_long_line();
      else repeat ($urandom_range(1, 3)) send_item(noise_item());
    end
  endtask

  task automatic test_lone_steps();
    send_item(make_step());
    send_item(make_line(5, -7, 1234, 5, -7, -99));
    send_item(make_step());
    send_item(make_line(-3, 4, 100, -2, 4, 200));
    send_item(make_step());
    send_item(make_step());
  endtask

  task automatic test_octants();
    int dxs[8] = '{2, 1, -1, -2, -2, -1, 1, 2};
    int dys[8] = '{1, 2, 2, 1, -1, -2, -2, -1};
    for (int i = 0; i < 8; i++) begin
      send_item(make_line(10, -10, 1000 * i - 3000, 10 + dxs[i], -10 + dys[i],
                          2000 - 700 * i));
      send_item(make_step());
    end
  endtask

  task automatic test_extremes();
    send_item(make_line(-2048, -2048, -32768, 2047, 2047, 32767));
    send_item(make_step());
    send_item(make_line(2047, -2048, 32767, -2048, 2047, -32768));
    send_item(make_step());
  endtask

  task automatic test_default_window();
    run_traffic(100);
  endtask

  task automatic test_tiny_window();
    settle_block();
    write_half(REG_HALF_WIDTH, 32'd1);
    write_half(REG_HALF_HEIGHT, 32'd1);
    run_traffic(105);
  endtask

  task automatic test_full_window();
    settle_block();
    write_half(REG_HALF_WIDTH, 32'd2047);
    write_half(REG_HALF_HEIGHT, 32'd2047);
    run_traffic(105);
  endtask

  task automatic test_masked_window();
    settle_block();
    // upper bits must be dropped: width lands on 0, height on 1029
    write_half(REG_HALF_WIDTH, 32'hFFFF_F800);
    write_half(REG_HALF_HEIGHT, 32'h0000_0C05);
    run_traffic(100);
  endtask

  task automatic test_random_windows();
    repeat (2) begin
      settle_block();
      write_half(REG_HALF_WIDTH, $urandom_range(1, 2047));
      write_half(REG_HALF_HEIGHT, $urandom_range(1, 2047));
      run_traffic(110);
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_lone_steps();
    test_octants();
    test_extremes();
    test_default_window();
    test_tiny_window();
    test_full_window();
    test_masked_window();
    test_random_windows();

    settle_block();
    repeat (20) @(posedge clk_i);
    if (pending_pixels.size() != 0)
      report_mismatch("pixels never delivered", 0, pending_pixels.size());
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// File: midpoint_line_rasterizer.f
src/mlr_pkg.sv
src/midpoint_line_rasterizer.sv
verif/midpoint_line_rasterizer_tb.sv
